FILE: src/wqhb_pkg.sv
package wqhb_pkg;

    localparam int HEAP_DEPTH   = 512;
    localparam int ARG_REGS     = 32;
    localparam int FUNCTOR_BITS = 8;

    localparam int HEAP_AW   = $clog2(HEAP_DEPTH);
    localparam int REG_AW    = $clog2(ARG_REGS);
    localparam int PTR_W     = HEAP_AW + 1;
    localparam int ARITY_W   = 4;
    localparam int TAG_W     = 2;
    localparam int FUN_W     = ARITY_W + FUNCTOR_BITS;
    localparam int PAYLOAD_W = (HEAP_AW > FUN_W) ? HEAP_AW : FUN_W;
    localparam int CELL_W    = TAG_W + PAYLOAD_W;

    typedef enum logic [1:0] {
        KIND_PUT_STRUCT = 2'd0,
        KIND_SET_VAR    = 2'd1,
        KIND_SET_VAL    = 2'd2,
        KIND_DEREF      = 2'd3
    } kind_t;

    typedef enum logic [TAG_W-1:0] {
        TAG_REF = 2'd0,
        TAG_STR = 2'd1,
        TAG_FUN = 2'd2
    } tag_t;

    typedef logic [CELL_W-1:0] cell_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] functor_code;
        logic [3:0] arg_count;
        logic [4:0] reg_index;
        logic [8:0] heap_addr;
    } wqhb_in_t;

    typedef struct packed {
        logic [8:0] resolved_addr;
        logic [1:0] resolved_tag;
        logic [9:0] build_top;
        logic       overflow;
    } wqhb_out_t;

    // Pointer cells: tag in the low bits, heap address right above it.
    function automatic cell_t make_ptr(tag_t tag, logic [HEAP_AW-1:0] addr);
        cell_t c;
        c = '0;
        c[TAG_W-1:0] = tag;
        c[TAG_W +: HEAP_AW] = addr;
        return c;
    endfunction

    // Functor cells: arity above the tag, functor identifier above the arity.
    function automatic cell_t make_fun(logic [ARITY_W-1:0] arity,
                                       logic [FUNCTOR_BITS-1:0] functor);
        cell_t c;
        c = '0;
        c[TAG_W-1:0] = TAG_FUN;
        c[TAG_W +: ARITY_W] = arity;
        c[TAG_W + ARITY_W +: FUNCTOR_BITS] = functor;
        return c;
    endfunction

endpackage

FILE: src/wqhb_ram.sv
module wqhb_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 14,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/wam_query_heap_builder.sv
// Query-building unit for a logic-programming abstract machine.
// Input channel s_valid/s_ready/s_data carries one instruction per beat:
// structure header, fresh variable, register copy or deref. Every
// instruction gives exactly one result beat on m_valid/m_ready/m_data with
// the resolved heap address and tag, the build pointer after the instruction,
// and an overflow flag when the heap had no room (then nothing is written).
// The heap and the argument registers sit in two synchronous RAMs with
// registered reads. Steps per instruction until the result register is
// loaded: fresh variable, one heap write; structure header, two heap writes
// on the single heap write port; register copy, register read, then heap
// write; deref, one heap read per link of the chain (at most HEAP_DEPTH + 1
// reads). Overflow cases load the result straight from the idle state.
// One instruction is processed at a time. A finished result sits in the
// output register; the next instruction is accepted while it waits, and if
// the receiver still stalls when that instruction completes, its result is
// held internally and s_ready stays low until the output register frees.
// Reset (aresetn low, synchronous) clears the build and allocation pointers
// and drops m_valid; heap and register contents are undefined until written.
module wam_query_heap_builder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  wqhb_pkg::wqhb_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output wqhb_pkg::wqhb_out_t m_data
);
    import wqhb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUT_FUN,
        ST_SET_VAL,
        ST_DEREF,
        ST_HOLD
    } state_t;

    state_t              state_reg, state_next;
    logic [PTR_W-1:0]    build_ptr_reg, build_ptr_next;
    logic [PTR_W-1:0]    alloc_top_reg, alloc_top_next;
    logic [HEAP_AW-1:0]  base_reg, base_next;
    cell_t               fun_cell_reg, fun_cell_next;
    logic [HEAP_AW-1:0]  cur_addr_reg, cur_addr_next;
    logic [PTR_W-1:0]    step_cnt_reg, step_cnt_next;
    logic [HEAP_AW-1:0]  res_addr_reg, res_addr_next;
    logic [TAG_W-1:0]    res_tag_reg, res_tag_next;
    logic                res_ovf_reg, res_ovf_next;
    logic                m_valid_reg, m_valid_next;
    wqhb_out_t           m_data_reg, m_data_next;

    logic                heap_we;
    logic [HEAP_AW-1:0]  heap_waddr, heap_raddr;
    cell_t               heap_wdata, heap_rdata;
    logic                arg_we;
    logic [REG_AW-1:0]   arg_addr;
    cell_t               arg_wdata, arg_rdata;

    logic                fin;
    logic [HEAP_AW-1:0]  fin_addr;
    logic [TAG_W-1:0]    fin_tag;
    logic                fin_ovf;
    logic                out_free;
    logic [PTR_W:0]      put_end;
    logic [HEAP_AW-1:0]  link_addr;
    logic [HEAP_AW-1:0]  build_addr;

    wqhb_ram #(.DEPTH(HEAP_DEPTH), .WIDTH(CELL_W)) u_heap (
        .aclk  (aclk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .raddr (heap_raddr),
        .rdata (heap_rdata)
    );

    wqhb_ram #(.DEPTH(ARG_REGS), .WIDTH(CELL_W)) u_args (
        .aclk  (aclk),
        .we    (arg_we),
        .waddr (arg_addr),
        .wdata (arg_wdata),
        .raddr (arg_addr),
        .rdata (arg_rdata)
    );

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;
    assign out_free   = !m_valid_reg || m_ready;
    assign arg_addr   = s_data.reg_index[REG_AW-1:0];
    assign put_end    = {1'b0, alloc_top_reg} + (PTR_W+1)'(s_data.arg_count)
                        + (PTR_W+1)'(2);
    assign link_addr  = heap_rdata[TAG_W +: HEAP_AW];
    assign build_addr = build_ptr_reg[HEAP_AW-1:0];

    always_comb begin
        state_next     = state_reg;
        build_ptr_next = build_ptr_reg;
        alloc_top_next = alloc_top_reg;
        base_next      = base_reg;
        fun_cell_next  = fun_cell_reg;
        cur_addr_next  = cur_addr_reg;
        step_cnt_next  = step_cnt_reg;
        res_addr_next  = res_addr_reg;
        res_tag_next   = res_tag_reg;
        res_ovf_next   = res_ovf_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;

        heap_we    = 1'b0;
        heap_waddr = build_addr;
        heap_wdata = '0;
        heap_raddr = cur_addr_reg;
        arg_we     = 1'b0;
        arg_wdata  = '0;

        fin      = 1'b0;
        fin_addr = '0;
        fin_tag  = TAG_REF;
        fin_ovf  = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                heap_raddr = s_data.heap_addr[HEAP_AW-1:0];
                if (s_valid) begin
                    case (kind_t'(s_data.kind))
                        KIND_PUT_STRUCT: begin
                            if (put_end > (PTR_W+1)'(HEAP_DEPTH)) begin
                                fin     = 1'b1;
                                fin_ovf = 1'b1;
                            end else begin
                                base_next  = alloc_top_reg[HEAP_AW-1:0];
                                heap_we    = 1'b1;
                                heap_waddr = alloc_top_reg[HEAP_AW-1:0];
                                heap_wdata = make_ptr(TAG_STR,
                                    alloc_top_reg[HEAP_AW-1:0] + HEAP_AW'(1));
                                arg_we     = 1'b1;
                                arg_wdata  = heap_wdata;
                                fun_cell_next  = make_fun(s_data.arg_count,
                                    s_data.functor_code[FUNCTOR_BITS-1:0]);
                                build_ptr_next = alloc_top_reg + PTR_W'(2);
                                alloc_top_next = put_end[PTR_W-1:0];
                                state_next     = ST_PUT_FUN;
                            end
                        end
                        KIND_SET_VAR: begin
                            if (build_ptr_reg >= PTR_W'(HEAP_DEPTH)) begin
                                fin     = 1'b1;
                                fin_ovf = 1'b1;
                            end else begin
                                heap_we        = 1'b1;
                                heap_wdata     = make_ptr(TAG_REF, build_addr);
                                arg_we         = 1'b1;
                                arg_wdata      = heap_wdata;
                                build_ptr_next = build_ptr_reg + PTR_W'(1);
                                fin            = 1'b1;
                                fin_addr       = build_addr;
                                fin_tag        = TAG_REF;
                            end
                        end
                        KIND_SET_VAL: begin
                            if (build_ptr_reg >= PTR_W'(HEAP_DEPTH)) begin
                                fin     = 1'b1;
                                fin_ovf = 1'b1;
                            end else begin
                                // The register file read is issued at this edge.
                                state_next = ST_SET_VAL;
                            end
                        end
                        KIND_DEREF: begin
                            cur_addr_next = s_data.heap_addr[HEAP_AW-1:0];
                            step_cnt_next = '0;
                            state_next    = ST_DEREF;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PUT_FUN: begin
                heap_we    = 1'b1;
                heap_waddr = base_reg + HEAP_AW'(1);
                heap_wdata = fun_cell_reg;
                fin        = 1'b1;
                fin_addr   = base_reg;
                fin_tag    = TAG_STR;
            end
            ST_SET_VAL: begin
                heap_we        = 1'b1;
                heap_wdata     = arg_rdata;
                build_ptr_next = build_ptr_reg + PTR_W'(1);
                fin            = 1'b1;
                fin_addr       = build_addr;
                fin_tag        = arg_rdata[TAG_W-1:0];
            end
            ST_DEREF: begin
                // A chain ends at a non-REF cell, an unbound variable, or when
                // the link budget is used up.
                if (heap_rdata[TAG_W-1:0] != TAG_REF || link_addr == cur_addr_reg
                        || step_cnt_reg == PTR_W'(HEAP_DEPTH)) begin
                    fin      = 1'b1;
                    fin_addr = cur_addr_reg;
                    fin_tag  = heap_rdata[TAG_W-1:0];
                end else begin
                    cur_addr_next = link_addr;
                    heap_raddr    = link_addr;
                    step_cnt_next = step_cnt_reg + PTR_W'(1);
                end
            end
            ST_HOLD: begin
                fin      = 1'b1;
                fin_addr = res_addr_reg;
                fin_tag  = res_tag_reg;
                fin_ovf  = res_ovf_reg;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (fin) begin
            if (out_free) begin
                m_valid_next              = 1'b1;
                m_data_next.resolved_addr = 9'(fin_addr);
                m_data_next.resolved_tag  = fin_tag;
                m_data_next.build_top     = 10'(build_ptr_next);
                m_data_next.overflow      = fin_ovf;
                state_next                = ST_IDLE;
            end else begin
                res_addr_next = fin_addr;
                res_tag_next  = fin_tag;
                res_ovf_next  = fin_ovf;
                state_next    = ST_HOLD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            build_ptr_reg <= '0;
            alloc_top_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            build_ptr_reg <= build_ptr_next;
            alloc_top_reg <= alloc_top_next;
            m_valid_reg   <= m_valid_next;
        end
        base_reg     <= base_next;
        fun_cell_reg <= fun_cell_next;
        cur_addr_reg <= cur_addr_next;
        step_cnt_reg <= step_cnt_next;
        res_addr_reg <= res_addr_next;
        res_tag_reg  <= res_tag_next;
        res_ovf_reg  <= res_ovf_next;
        m_data_reg   <= m_data_next;
    end

endmodule

FILE: src/wqhb_checker.sv
module wqhb_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input wqhb_pkg::wqhb_out_t m_data
);
    import wqhb_pkg::*;

    // Beats accepted on the input side whose results are not yet delivered.
    logic [1:0] pending_reg, pending_next;
    logic       in_beat, out_beat;

    assign in_beat  = s_valid && s_ready;
    assign out_beat = m_valid && m_ready;

    always_comb begin
        pending_next = pending_reg;
        if (in_beat && !out_beat) begin
            pending_next = pending_reg + 2'd1;
        end else if (out_beat && !in_beat) begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed or dropped while stalled");

    a_no_extra_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 2'd0)
        else $error("result beat without an accepted instruction");

    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg != 2'd3)
        else $error("more than two instructions in flight");

    a_overflow_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.overflow |-> m_data.resolved_addr == 9'd0
            && m_data.resolved_tag == TAG_REF)
        else $error("overflow result carries a cell");

    a_top_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.build_top <= 10'(HEAP_DEPTH))
        else $error("build pointer beyond the heap");

endmodule

bind wam_query_heap_builder wqhb_checker u_wqhb_checker (.*);

FILE: tb/sv/wam_query_heap_builder_test.sv
`timescale 1ns / 1ps

module wam_query_heap_builder_test;
    import wqhb_pkg::*;

    localparam int SHADOW = 0;
    localparam int MIRROR = 1;
    localparam int RANDOM_ITEMS = 530;
    localparam int MAX_ITEMS = 620;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = HEAP_DEPTH + 100;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    wqhb_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    wqhb_out_t m_data;

    wam_query_heap_builder DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Two copies of the machine: one steers stimulus generation, the other
    // advances as instructions are actually accepted by the block.
    cell_t           heap_img [2][HEAP_DEPTH];
    cell_t           reg_img  [2][ARG_REGS];
    logic [PTR_W-1:0] build_ptr [2];
    logic [PTR_W-1:0] alloc_top [2];

    bit heap_seen [HEAP_DEPTH];
    bit reg_seen  [ARG_REGS];
    int written_cells [$];
    int written_regs  [$];

    wqhb_in_t  instr_queue [$];
    wqhb_out_t pending_results [$];

    int n_struct, n_set, n_deref, n_full;
    int n_checked, n_errors;
    int cycle_cnt;
    int gap_left, burst_left, stall_left;
    logic calm;

    function automatic wqhb_out_t run_instruction(int img, wqhb_in_t ins);
        wqhb_out_t r;
        cell_t     c;
        int        base, need, h, a, nxt, hops;
        r = '0;
        r.build_top = build_ptr[img];
        r.overflow = 1'b1;
        case (kind_t'(ins.kind))
            KIND_PUT_STRUCT: begin
                base = alloc_top[img];
                need = ins.arg_count + 2;
                if (base + need <= HEAP_DEPTH) begin
                    heap_img[img][base] = cell_t'({HEAP_AW'(base + 1), TAG_STR});
                    heap_img[img][base + 1] =
                        cell_t'({ins.functor_code, ins.arg_count, TAG_FUN});
                    reg_img[img][ins.reg_index] = heap_img[img][base];
                    build_ptr[img] = PTR_W'(base + 2);
                    alloc_top[img] = PTR_W'(base + need);
                    r.resolved_addr = base[HEAP_AW-1:0];
                    r.resolved_tag = TAG_STR;
                    r.build_top = build_ptr[img];
                    r.overflow = 1'b0;
                end
            end
            KIND_SET_VAR, KIND_SET_VAL: begin
                h = build_ptr[img];
                if (h < HEAP_DEPTH) begin
                    if (kind_t'(ins.kind) == KIND_SET_VAR) begin
                        c = cell_t'({h[HEAP_AW-1:0], TAG_REF});
                        reg_img[img][ins.reg_index] = c;
                    end else begin
                        c = reg_img[img][ins.reg_index];
                    end
                    heap_img[img][h] = c;
                    build_ptr[img] = PTR_W'(h + 1);
                    r.resolved_addr = h[HEAP_AW-1:0];
                    r.resolved_tag = c[TAG_W-1:0];
                    r.build_top = build_ptr[img];
                    r.overflow = 1'b0;
                end
            end
            default: begin
                // Follow REF links until a self-reference, a bound cell or the hop limit.
                a = ins.heap_addr;
                hops = 0;
                while (hops < HEAP_DEPTH) begin
                    c = heap_img[img][a];
                    if (c[TAG_W-1:0] != TAG_REF) break;
                    nxt = c[TAG_W +: HEAP_AW];
                    if (nxt == a) break;
                    a = nxt;
                    hops++;
                end
                r.resolved_addr = a[HEAP_AW-1:0];
                r.resolved_tag = heap_img[img][a][TAG_W-1:0];
                r.overflow = 1'b0;
            end
        endcase
        return r;
    endfunction

    function automatic void mark_cell(int a);
        if (!heap_seen[a]) begin
            heap_seen[a] = 1'b1;
            written_cells.push_back(a);
        end
    endfunction

    function automatic void mark_reg(int rg);
        if (!reg_seen[rg]) begin
            reg_seen[rg] = 1'b1;
            written_regs.push_back(rg);
        end
    endfunction

    // Queues one instruction and tracks which cells and registers now hold
    // data, so that later reads only ever touch written entries.
    function automatic void add_instr(kind_t k, int fcode, int arity, int rg, int addr);
        wqhb_in_t  ins;
        wqhb_out_t r;
        ins = '0;
        ins.kind = k;
        ins.functor_code = fcode[7:0];
        ins.arg_count = arity[3:0];
        ins.reg_index = rg[4:0];
        ins.heap_addr = addr[8:0];
        r = run_instruction(SHADOW, ins);
        instr_queue.push_back(ins);
        if (r.overflow) n_full++;
        case (k)
            KIND_PUT_STRUCT: begin
                n_struct++;
                if (!r.overflow) begin
                    mark_cell(r.resolved_addr);
                    mark_cell(r.resolved_addr + 1);
                    mark_reg(ins.reg_index);
                end
            end
            KIND_SET_VAR: begin
                n_set++;
                if (!r.overflow) begin
                    mark_cell(r.resolved_addr);
                    mark_reg(ins.reg_index);
                end
            end
            KIND_SET_VAL: begin
                n_set++;
                if (!r.overflow) mark_cell(r.resolved_addr);
            end
            default: n_deref++;
        endcase
    endfunction

    function automatic void add_random_set();
        if (written_regs.size() == 0 || $urandom_range(0, 2) == 0)
            add_instr(KIND_SET_VAR, $urandom_range(0, 255), $urandom_range(0, 15),
                      $urandom_range(0, ARG_REGS - 1), $urandom_range(0, HEAP_DEPTH - 1));
        else
            add_instr(KIND_SET_VAL, $urandom_range(0, 255), $urandom_range(0, 15),
                      written_regs[$urandom_range(0, written_regs.size() - 1)],
                      $urandom_range(0, HEAP_DEPTH - 1));
    endfunction

    function automatic void add_random_deref();
        add_instr(KIND_DEREF, $urandom_range(0, 255), $urandom_range(0, 15),
                  $urandom_range(0, ARG_REGS - 1),
                  written_cells[$urandom_range(0, written_cells.size() - 1)]);
    endfunction

    // A structure followed by its argument cells, now and then cut short or
    // overrun so that the build pointer runs past the allocation.
    function automatic void add_random_structure();
        int room, arity, n_args;
        room = HEAP_DEPTH - int'(alloc_top[SHADOW]);
        if (room >= 2 && room <= 17 && $urandom_range(0, 3) != 0)
            arity = room - 2;
        else
            arity = $urandom_range(0, 15);
        add_instr(KIND_PUT_STRUCT, $urandom_range(0, 255), arity,
                  $urandom_range(0, ARG_REGS - 1), $urandom_range(0, HEAP_DEPTH - 1));
        n_args = ($urandom_range(0, 5) == 0) ? $urandom_range(0, arity + 3) : arity;
        for (int i = 0; i < n_args; i++) begin
            if ($urandom_range(0, 4) == 0) add_random_deref();
            add_random_set();
        end
    endfunction

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Calm stretches, one quarter of the run, start no new input gaps or output stalls.
    assign calm = (cycle_cnt[10:9] == 2'd0);

    always @(posedge aclk) begin
        logic     nv;
        wqhb_in_t nd;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data <= '0;
            gap_left = 0;
            burst_left = 0;
        end else begin
            if (s_valid && s_ready)
                pending_results.push_back(run_instruction(MIRROR, s_data));
            if (!s_valid || s_ready) begin
                nv = 1'b0;
                nd = s_data;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (instr_queue.size() > 0) begin
                    nv = 1'b1;
                    nd = instr_queue.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = calm ? 0 : $urandom_range(0, 6);
                    end
                end
                s_valid <= nv;
                s_data <= nd;
            end
        end
    end

    always @(posedge aclk) begin
        wqhb_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                n_checked++;
                if (pending_results.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result beat: addr=%0d tag=%0d H=%0d ovf=%0d",
                             $time, m_data.resolved_addr, m_data.resolved_tag,
                             m_data.build_top, m_data.overflow);
                end else begin
                    want = pending_results.pop_front();
                    if (m_data !== want) begin
                        n_errors++;
                        $display("%0t: mismatch: expected addr=%0d tag=%0d H=%0d ovf=%0d",
                                 $time, want.resolved_addr, want.resolved_tag,
                                 want.build_top, want.overflow);
                        $display("%0t: mismatch: actual   addr=%0d tag=%0d H=%0d ovf=%0d",
                                 $time, m_data.resolved_addr, m_data.resolved_tag,
                                 m_data.build_top, m_data.overflow);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 8);
            end
        end
    end

    initial begin
        int directed;
        for (int i = 0; i < 2; i++) begin
            build_ptr[i] = '0;
            alloc_top[i] = '0;
        end
        foreach (heap_img[p, q]) heap_img[p][q] = '0;
        foreach (reg_img[p, q]) reg_img[p][q] = '0;
        cycle_cnt = 0;

        // Smallest and largest structures, then bound, unbound and chained
        // cells, and a structure whose argument cells are left short.
        add_instr(KIND_PUT_STRUCT, 0, 0, 0, 0);
        add_instr(KIND_PUT_STRUCT, 255, 15, 31, 511);
        add_instr(KIND_SET_VAR, 0, 0, 1, 0);
        add_instr(KIND_SET_VAL, 0, 0, 31, 0);
        add_instr(KIND_SET_VAL, 0, 0, 1, 0);
        add_instr(KIND_SET_VAL, 0, 0, 0, 0);
        add_instr(KIND_SET_VAR, 255, 15, 2, 511);
        add_instr(KIND_SET_VAL, 255, 15, 2, 511);
        add_instr(KIND_DEREF, 0, 0, 0, 0);
        add_instr(KIND_DEREF, 255, 15, 31, 1);
        add_instr(KIND_DEREF, 0, 0, 0, 4);
        add_instr(KIND_DEREF, 0, 0, 0, 6);
        add_instr(KIND_DEREF, 0, 0, 0, 5);
        add_instr(KIND_DEREF, 0, 0, 0, 9);
        add_instr(KIND_PUT_STRUCT, 170, 3, 5, 0);
        add_instr(KIND_SET_VAR, 85, 10, 3, 170);
        add_instr(KIND_SET_VAL, 0, 0, 5, 0);
        add_instr(KIND_SET_VAR, 0, 0, 4, 0);
        add_instr(KIND_DEREF, 0, 0, 0, 20);
        add_instr(KIND_DEREF, 0, 0, 0, 21);
        directed = instr_queue.size();

        // Keep going a little past the item count while the full-heap paths
        // are still rare, but never far beyond it.
        while ((instr_queue.size() < directed + RANDOM_ITEMS || n_full < 20) &&
               instr_queue.size() < MAX_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1) == 0) add_random_set();
                else add_random_deref();
            end else begin
                add_random_structure();
            end
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (instr_queue.size() > 0 || s_valid) @(posedge aclk);
        while (pending_results.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d instructions: %0d structure headers, %0d cell builds, %0d derefs.",
                 n_struct + n_set + n_deref, n_struct, n_set, n_deref);
        $display("Heap filled to H=%0d with %0d heap-full results; %0d result beats checked.",
                 build_ptr[MIRROR], n_full, n_checked);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
